>>> src/bcre_pkg.sv
package bcre_pkg;

	// Fixed field widths of the block's ports.
	localparam int COL_W      = 9;
	localparam int ROW_W      = 8;
	localparam int OUT_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int IMAGE_WIDTH_DEF = 320;
	localparam int EDGE_LOW        = 2;

	// Iteration counts of the long-division and square-root units.
	localparam int DIV_STEPS = 25;
	localparam int SEC_STEPS = 23;
	localparam int DEN_W     = 30;

	// A cosine of 0.01 or less means dx^2 >= 9999 * fx^2.
	localparam logic [13:0] COS_LIMIT = 14'd9999;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRINCIPAL_X   = 3'd0,
		REG_FOCAL_X       = 3'd1,
		REG_FOOT_SLOPE    = 3'd2,
		REG_HORIZON_ROW   = 3'd3,
		REG_GROUND_SCALE  = 3'd4,
		REG_FOCAL_HEIGHT  = 3'd5,
		REG_CLIPPED_RANGE = 3'd6
	} cfg_reg_t;

	localparam logic [12:0] PRINCIPAL_X_RST = 13'd2560;
	localparam logic [15:0] FOCAL_X_RST     = 16'd4096;

	// Per-request flags that travel down the pipeline with the data.
	typedef struct packed {
		logic edge_hit;
		logic ground;
		logic cos_ok;
	} flags_t;

endpackage

>>> src/blob_camera_range_estimator.sv
// Throughput: one request per cycle; the whole pipeline advances together and holds
// only while a finished result waits for out_ready.
// Reset: arst_n clears all valid bits and loads the register defaults at once;
// no clearing pass, the block accepts requests right after reset.
module blob_camera_range_estimator #(
	parameter int IMAGE_WIDTH = bcre_pkg::IMAGE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [bcre_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bcre_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             blob_found,
	input  logic [bcre_pkg::COL_W-1:0]       center_col,
	input  logic [bcre_pkg::COL_W-1:0]       left_col,
	input  logic [bcre_pkg::COL_W-1:0]       right_col,
	input  logic [bcre_pkg::ROW_W-1:0]       bottom_row,
	input  logic [bcre_pkg::ROW_W-1:0]       blob_rows,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bcre_pkg::OUT_W-1:0]       range_mm,
	output logic [bcre_pkg::OUT_W-1:0]       forward_mm,
	output logic                             side_touch,
	output logic                             ground_fit_used,
	output logic                             saturated
);
	import bcre_pkg::*;

	// The right edge limit follows the image width; it is compared in a
	// width that holds the largest supported image.
	localparam logic [10:0]      RIGHT_EDGE = 11'(IMAGE_WIDTH - 3);
	localparam logic [COL_W-1:0] LEFT_EDGE  = COL_W'(EDGE_LOW);

	// Configuration registers. The user must write them only while the pipeline
	// is empty, which the block itself does not enforce; every stage reads them directly.
	logic        [12:0] principal_x_q;
	logic        [15:0] focal_x_q;
	logic signed [15:0] foot_slope_q;
	logic        [12:0] horizon_row_q;
	logic        [23:0] ground_scale_q;
	logic        [23:0] focal_height_q;
	logic        [15:0] clipped_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_x_q   <= PRINCIPAL_X_RST;
			focal_x_q       <= FOCAL_X_RST;
			foot_slope_q    <= '0;
			horizon_row_q   <= '0;
			ground_scale_q  <= '0;
			focal_height_q  <= '0;
			clipped_range_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_PRINCIPAL_X:   principal_x_q   <= cfg_data[12:0];
				REG_FOCAL_X:       focal_x_q       <= cfg_data[15:0];
				REG_FOOT_SLOPE:    foot_slope_q    <= cfg_data[15:0];
				REG_HORIZON_ROW:   horizon_row_q   <= cfg_data[12:0];
				REG_GROUND_SCALE:  ground_scale_q  <= cfg_data;
				REG_FOCAL_HEIGHT:  focal_height_q  <= cfg_data;
				REG_CLIPPED_RANGE: clipped_range_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// All stages move together. The pipeline stalls only when the output
	// register holds a result that has not been taken.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Stage 1: horizontal offset from the optical center and the edge test.
	logic [12:0] c16_c, dx_c;
	logic        edge_c;
	logic        v_s1, found_s1, edge_s1;
	logic [12:0] dx_s1;
	logic [7:0]  bottom_s1, rows_s1;

	assign c16_c  = {center_col, 4'b0000};
	assign dx_c   = (c16_c >= principal_x_q) ? (c16_c - principal_x_q)
	                                         : (principal_x_q - c16_c);
	assign edge_c = (left_col <= LEFT_EDGE) || ({2'b00, right_col} >= RIGHT_EDGE);

	always_ff @(posedge clk) begin
		if (en) begin
			found_s1  <= blob_found;
			edge_s1   <= blob_found && edge_c;
			dx_s1     <= dx_c;
			bottom_s1 <= bottom_row;
			rows_s1   <= blob_rows;
		end
	end

	// Stage 2: the three products (slope times offset, dx^2, fx^2).
	logic               found_s2, edge_s2;
	logic signed [29:0] sprod_s2;
	logic        [25:0] dx2_s2;
	logic        [31:0] fx2_s2;
	logic        [7:0]  bottom_s2, rows_s2;
	logic               v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			found_s2  <= found_s1;
			edge_s2   <= edge_s1;
			sprod_s2  <= foot_slope_q * $signed({1'b0, dx_s1});
			dx2_s2    <= dx_s1 * dx_s1;
			fx2_s2    <= focal_x_q * focal_x_q;
			bottom_s2 <= bottom_s1;
			rows_s2   <= rows_s1;
		end
	end

	// Stage 3: ground denominator in 1/65536 pixel, the radicand and the
	// cosine limit.
	logic               found_s3, edge_s3;
	logic signed [30:0] d_s3;
	logic        [32:0] s_s3;
	logic        [45:0] lim_s3;
	logic        [25:0] dx2_s3;
	logic        [7:0]  rows_s3;
	logic               v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			found_s3 <= found_s2;
			edge_s3  <= edge_s2;
			d_s3     <= $signed({7'b0, bottom_s2, 16'b0}) - 31'(sprod_s2)
			            - $signed({{6{horizon_row_q[12]}}, horizon_row_q, 12'b0});
			s_s3     <= 33'(fx2_s2) + 33'(dx2_s2);
			lim_s3   <= 46'(fx2_s2) * 46'(COS_LIMIT);
			dx2_s3   <= dx2_s2;
			rows_s3  <= rows_s2;
		end
	end

	// Stage 4: pick the divider operands. The clipped range, an absent blob
	// and a zero blob height all go through the same divider as a
	// division by one.
	logic        ground_c, fallback_c;
	logic [39:0] num_c;
	logic [DEN_W-1:0] den_c;

	assign ground_c   = found_s3 && !edge_s3 && (d_s3 > 31'sd65536);
	assign fallback_c = found_s3 && !edge_s3 && !ground_c && (rows_s3 != '0);

	always_comb begin
		priority if (edge_s3) begin
			num_c = {24'b0, clipped_range_q};
			den_c = DEN_W'(1);
		end else if (ground_c) begin
			num_c = {ground_scale_q, 16'b0};
			den_c = d_s3[DEN_W-1:0];
		end else if (fallback_c) begin
			num_c = {16'b0, focal_height_q};
			den_c = {{(DEN_W-ROW_W){1'b0}}, rows_s3};
		end else begin
			num_c = '0;
			den_c = DEN_W'(1);
		end
	end

	logic [DEN_W-1:0] fd_rem_s4, fd_den_s4;
	logic [24:0]      fd_nb_s4;
	logic [49:0]      sq_x_s4;
	flags_t           fl_s4;
	logic             v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			// The quotient stays below 2^24, so the top bits start the remainder.
			fd_rem_s4 <= {{(DEN_W-15){1'b0}}, num_c[39:25]};
			fd_nb_s4  <= num_c[24:0];
			fd_den_s4 <= den_c;
			sq_x_s4   <= {1'b0, s_s3, 16'b0};
			fl_s4     <= '{edge_hit: edge_s3, ground: ground_c,
			               cos_ok: (46'(dx2_s3) < lim_s3)};
		end
	end

	// Stages 5 to 29: one quotient bit of the depth division and one root
	// bit of the secant square root per stage, side by side.
	logic [DEN_W-1:0] fd_rem_s [1:DIV_STEPS];
	logic [DEN_W-1:0] fd_den_s [1:DIV_STEPS];
	logic [24:0]      fd_nb_s  [1:DIV_STEPS];
	logic [24:0]      fd_q_s   [1:DIV_STEPS];
	logic [25:0]      sq_rem_s [1:DIV_STEPS];
	logic [49:0]      sq_x_s   [1:DIV_STEPS];
	logic [24:0]      sq_root_s[1:DIV_STEPS];
	flags_t           mfl_s    [1:DIV_STEPS];
	logic             mv_s     [1:DIV_STEPS];

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_main
		logic [DEN_W-1:0] rem_p, den_p;
		logic [24:0]      nb_p, q_p, root_p;
		logic [25:0]      srem_p;
		logic [49:0]      sx_p;
		flags_t           fl_p;
		logic             v_p;
		logic [DEN_W:0]   rsh;
		logic [27:0]      ssh, strial;

		if (k == 1) begin : g_src
			assign rem_p  = fd_rem_s4;
			assign den_p  = fd_den_s4;
			assign nb_p   = fd_nb_s4;
			assign q_p    = '0;
			assign srem_p = '0;
			assign sx_p   = sq_x_s4;
			assign root_p = '0;
			assign fl_p   = fl_s4;
			assign v_p    = v_s4;
		end else begin : g_src
			assign rem_p  = fd_rem_s[k-1];
			assign den_p  = fd_den_s[k-1];
			assign nb_p   = fd_nb_s[k-1];
			assign q_p    = fd_q_s[k-1];
			assign srem_p = sq_rem_s[k-1];
			assign sx_p   = sq_x_s[k-1];
			assign root_p = sq_root_s[k-1];
			assign fl_p   = mfl_s[k-1];
			assign v_p    = mv_s[k-1];
		end

		assign rsh    = {rem_p, nb_p[24]};
		assign ssh    = {srem_p, sx_p[49:48]};
		assign strial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				mv_s[k] <= 1'b0;
			end else if (en) begin
				mv_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= {1'b0, den_p}) begin
					fd_rem_s[k] <= DEN_W'(rsh - {1'b0, den_p});
					fd_q_s[k]   <= {q_p[23:0], 1'b1};
				end else begin
					fd_rem_s[k] <= rsh[DEN_W-1:0];
					fd_q_s[k]   <= {q_p[23:0], 1'b0};
				end
				fd_nb_s[k]  <= {nb_p[23:0], 1'b0};
				fd_den_s[k] <= den_p;

				if (ssh >= strial) begin
					sq_rem_s[k]  <= 26'(ssh - strial);
					sq_root_s[k] <= {root_p[23:0], 1'b1};
				end else begin
					sq_rem_s[k]  <= ssh[25:0];
					sq_root_s[k] <= {root_p[23:0], 1'b0};
				end
				sq_x_s[k] <= {sx_p[47:0], 2'b00};
				mfl_s[k]  <= fl_p;
			end
		end
	end

	// Stages 30 to 52: secant in Q16, root * 256 / focal_x, one bit per stage.
	// When the cosine test fails the quotient is meaningless and is masked later.
	logic [15:0] sd_rem_s[1:SEC_STEPS];
	logic [22:0] sd_nb_s [1:SEC_STEPS];
	logic [22:0] sd_q_s  [1:SEC_STEPS];
	logic [23:0] fw_s    [1:SEC_STEPS];
	flags_t      sfl_s   [1:SEC_STEPS];
	logic        sv_s    [1:SEC_STEPS];

	for (genvar j = 1; j <= SEC_STEPS; j++) begin : g_sec
		logic [15:0] rem_p;
		logic [22:0] nb_p, q_p;
		logic [23:0] fw_p;
		flags_t      fl_p;
		logic        v_p;
		logic [16:0] rsh;

		if (j == 1) begin : g_src
			assign rem_p = {6'b0, sq_root_s[DIV_STEPS][24:15]};
			assign nb_p  = {sq_root_s[DIV_STEPS][14:0], 8'b0};
			assign q_p   = '0;
			assign fw_p  = fd_q_s[DIV_STEPS][23:0];
			assign fl_p  = mfl_s[DIV_STEPS];
			assign v_p   = mv_s[DIV_STEPS];
		end else begin : g_src
			assign rem_p = sd_rem_s[j-1];
			assign nb_p  = sd_nb_s[j-1];
			assign q_p   = sd_q_s[j-1];
			assign fw_p  = fw_s[j-1];
			assign fl_p  = sfl_s[j-1];
			assign v_p   = sv_s[j-1];
		end

		assign rsh = {rem_p, nb_p[22]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_s[j] <= 1'b0;
			end else if (en) begin
				sv_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= {1'b0, focal_x_q}) begin
					sd_rem_s[j] <= 16'(rsh - {1'b0, focal_x_q});
					sd_q_s[j]   <= {q_p[21:0], 1'b1};
				end else begin
					sd_rem_s[j] <= rsh[15:0];
					sd_q_s[j]   <= {q_p[21:0], 1'b0};
				end
				sd_nb_s[j] <= {nb_p[21:0], 1'b0};
				fw_s[j]    <= fw_p;
				sfl_s[j]   <= fl_p;
			end
		end
	end

	// Stage 53: forward depth times secant.
	logic [46:0] prod_s53;
	logic [23:0] fwd_s53;
	flags_t      fl_s53;
	logic        v_s53;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s53 <= fw_s[SEC_STEPS] * sd_q_s[SEC_STEPS];
			fwd_s53  <= fw_s[SEC_STEPS];
			fl_s53   <= sfl_s[SEC_STEPS];
		end
	end

	// Stage 54: the output register, with clamping to 16 bits.
	logic [30:0] range_c;
	logic        fwd_big_c, range_big_c;
	logic        v_s54;

	assign range_c     = fl_s53.cos_ok ? prod_s53[46:16] : '0;
	assign fwd_big_c   = (fwd_s53[23:16] != '0);
	assign range_big_c = (range_c[30:16] != '0);

	always_ff @(posedge clk) begin
		if (en) begin
			forward_mm      <= fwd_big_c ? '1 : fwd_s53[15:0];
			range_mm        <= range_big_c ? '1 : range_c[15:0];
			saturated       <= fwd_big_c || range_big_c;
			side_touch      <= fl_s53.edge_hit;
			ground_fit_used <= fl_s53.ground;
		end
	end

	// Valid bits of the fixed stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s53 <= 1'b0;
			v_s54 <= 1'b0;
		end else if (en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s53 <= sv_s[SEC_STEPS];
			v_s54 <= v_s53;
		end
	end

	assign out_valid = v_s54;

	// An edge-clipped blob never uses the ground-plane fit.
	a_edge_not_ground: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(side_touch && ground_fit_used))
		else $error("edge-clipped result flagged as ground fit");

	// A zero forward depth always gives a zero range.
	a_zero_fwd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && forward_mm == '0) |-> (range_mm == '0))
		else $error("nonzero range with zero forward depth");

	// With the output register empty the pipeline never stalls.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request refused while output register empty");

endmodule
